// File: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, codes and the microcode program of the linear congruence
// solver.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int MOD_RESET = 961;
   localparam int STEP_W    = 5;

   typedef enum logic [1:0] {
      STATUS_UNIQUE = 2'd0,
      STATUS_NONE   = 2'd1,
      STATUS_MULTI  = 2'd2,
      STATUS_RANGE  = 2'd3
   } status_type;

   // datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_DIV_EUCLID,   // start r0 / r1
      OP_MUL_QT,       // prod = q * t1
      OP_UPDATE,       // shift remainder and coefficient pairs
      OP_DIV_STEP,     // start m / g
      OP_SAVE_STEP,    // step = quotient, start b / g
      OP_SAVE_BQ,      // b / g and its remainder flag
      OP_FIX_T,        // tr = t0, moved up by step when negative
      OP_WRAP_T,       // tr = tr - step when tr >= step
      OP_MUL_TB,       // prod = tr * (b / g)
      OP_DIV_SOL,      // start prod / step (long)
      OP_FIN_OK,
      OP_FIN_NOSOL,
      OP_FIN_ERR
   } op_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_RANGE,
      CND_R1_ZERO,
      CND_DIV_BUSY,
      CND_REM_NZ
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              done;
   } ctrl_word_type;

   typedef struct packed {
      logic range_err;
      logic r1_zero;
      logic div_busy;
      logic rem_nz;
      logic out_blocked;
   } flags_type;

   // program labels
   localparam logic [STEP_W-1:0] S_CHECK = 5'd0;
   localparam logic [STEP_W-1:0] S_LOOP  = 5'd1;
   localparam logic [STEP_W-1:0] S_DIVQ  = 5'd2;
   localparam logic [STEP_W-1:0] S_WAITQ = 5'd3;
   localparam logic [STEP_W-1:0] S_MULQ  = 5'd4;
   localparam logic [STEP_W-1:0] S_UPD   = 5'd5;
   localparam logic [STEP_W-1:0] S_EXIT  = 5'd6;
   localparam logic [STEP_W-1:0] S_WAITS = 5'd7;
   localparam logic [STEP_W-1:0] S_DIVB  = 5'd8;
   localparam logic [STEP_W-1:0] S_WAITB = 5'd9;
   localparam logic [STEP_W-1:0] S_SAVEB = 5'd10;
   localparam logic [STEP_W-1:0] S_FIXT  = 5'd11;
   localparam logic [STEP_W-1:0] S_WRAPT = 5'd12;
   localparam logic [STEP_W-1:0] S_MULT  = 5'd13;
   localparam logic [STEP_W-1:0] S_DIVS  = 5'd14;
   localparam logic [STEP_W-1:0] S_WAITD = 5'd15;
   localparam logic [STEP_W-1:0] S_OK    = 5'd16;
   localparam logic [STEP_W-1:0] S_NOSOL = 5'd17;
   localparam logic [STEP_W-1:0] S_ERR   = 5'd18;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] addr);
      ctrl_word_type cw;
      cw = '{op: OP_NOP, cond: CND_NEVER, target: S_CHECK, done: 1'b0};
      case (addr)
         S_CHECK: cw = '{OP_NOP,        CND_RANGE,    S_ERR,   1'b0};
         S_LOOP:  cw = '{OP_NOP,        CND_R1_ZERO,  S_EXIT,  1'b0};
         S_DIVQ:  cw = '{OP_DIV_EUCLID, CND_NEVER,    S_CHECK, 1'b0};
         S_WAITQ: cw = '{OP_NOP,        CND_DIV_BUSY, S_WAITQ, 1'b0};
         S_MULQ:  cw = '{OP_MUL_QT,     CND_NEVER,    S_CHECK, 1'b0};
         S_UPD:   cw = '{OP_UPDATE,     CND_ALWAYS,   S_LOOP,  1'b0};
         S_EXIT:  cw = '{OP_DIV_STEP,   CND_NEVER,    S_CHECK, 1'b0};
         S_WAITS: cw = '{OP_NOP,        CND_DIV_BUSY, S_WAITS, 1'b0};
         S_DIVB:  cw = '{OP_SAVE_STEP,  CND_NEVER,    S_CHECK, 1'b0};
         S_WAITB: cw = '{OP_NOP,        CND_DIV_BUSY, S_WAITB, 1'b0};
         S_SAVEB: cw = '{OP_SAVE_BQ,    CND_NEVER,    S_CHECK, 1'b0};
         S_FIXT:  cw = '{OP_FIX_T,      CND_REM_NZ,   S_NOSOL, 1'b0};
         S_WRAPT: cw = '{OP_WRAP_T,     CND_NEVER,    S_CHECK, 1'b0};
         S_MULT:  cw = '{OP_MUL_TB,     CND_NEVER,    S_CHECK, 1'b0};
         S_DIVS:  cw = '{OP_DIV_SOL,    CND_NEVER,    S_CHECK, 1'b0};
         S_WAITD: cw = '{OP_NOP,        CND_DIV_BUSY, S_WAITD, 1'b0};
         S_OK:    cw = '{OP_FIN_OK,     CND_NEVER,    S_CHECK, 1'b1};
         S_NOSOL: cw = '{OP_FIN_NOSOL,  CND_NEVER,    S_CHECK, 1'b1};
         S_ERR:   cw = '{OP_FIN_ERR,    CND_NEVER,    S_CHECK, 1'b1};
         default: cw = '{OP_FIN_ERR,    CND_NEVER,    S_CHECK, 1'b1};
      endcase
      return cw;
   endfunction

endpackage

// File: rtl/lcs_divider.sv
// ----------------------------------------------------------------------------
// lcs_divider
// Restoring divider, one quotient bit per cycle. Short mode divides a
// WIDTH-bit dividend, long mode a 2*WIDTH-bit one.
// ----------------------------------------------------------------------------
module lcs_divider #(
   parameter int WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               long_mode,
   input  logic [2*WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0]   divisor,
   output logic               busy,
   output logic [2*WIDTH-1:0] quotient,
   output logic [WIDTH-1:0]   remainder
);

   localparam int CNT_W = $clog2(2*WIDTH+1);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [2*WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0]   dvs_ff, dvs_in;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH:0]     trial;
   logic [WIDTH:0]     diff;
   logic               fits;

   always_comb begin
      trial  = {rem_ff, dvd_ff[2*WIDTH-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      if (start) begin
         dvs_in = divisor;
         rem_in = '0;
         if (long_mode) begin
            dvd_in = dividend;
            cnt_in = CNT_W'(2*WIDTH);
         end else begin
            // quotient bits land in the low half as the dividend shifts out
            dvd_in = {dividend[WIDTH-1:0], {WIDTH{1'b0}}};
            cnt_in = CNT_W'(WIDTH);
         end
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         dvd_in = {dvd_ff[2*WIDTH-2:0], fits};
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/lcs_datapath.sv
// ----------------------------------------------------------------------------
// lcs_datapath
// Euclid registers, coefficient update, multiplier, shared divider and the
// result register, driven one op per cycle by the sequencer when not stalled.
// ----------------------------------------------------------------------------
module lcs_datapath #(
   parameter int WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [WIDTH-1:0]     coef_a,
   input  logic [WIDTH-1:0]     rhs_b,
   input  logic [WIDTH-1:0]     modulus,
   input  lcs_pkg::op_type      op,
   input  logic                 rsp_tready,
   output lcs_pkg::flags_type   flags,
   output logic                 rsp_valid,
   output logic [WIDTH-1:0]     solution,
   output logic [WIDTH-1:0]     solution_step,
   output logic [WIDTH-1:0]     gcd_value,
   output lcs_pkg::status_type  status
);

   logic [WIDTH-1:0]          m_ff, m_in;
   logic [WIDTH-1:0]          b_ff, b_in;
   logic [WIDTH-1:0]          r0_ff, r0_in;
   logic [WIDTH-1:0]          r1_ff, r1_in;
   logic signed [WIDTH:0]     t0_ff, t0_in;
   logic signed [WIDTH:0]     t1_ff, t1_in;
   logic signed [2*WIDTH:0]   prod_ff, prod_in;
   logic [WIDTH-1:0]          step_ff, step_in;
   logic [WIDTH-1:0]          bq_ff, bq_in;
   logic                      rem_nz_ff, rem_nz_in;
   logic [WIDTH-1:0]          tr_ff, tr_in;
   logic                      out_valid_ff, out_valid_in;
   logic [WIDTH-1:0]          sol_ff, sol_in;
   logic [WIDTH-1:0]          ostep_ff, ostep_in;
   logic [WIDTH-1:0]          gcd_ff, gcd_in;
   lcs_pkg::status_type       status_ff, status_in;

   logic                      div_start;
   logic                      div_long;
   logic [2*WIDTH-1:0]        div_dividend;
   logic [WIDTH-1:0]          div_divisor;
   logic                      div_busy;
   logic [2*WIDTH-1:0]        div_quot;
   logic [WIDTH-1:0]          div_rem;
   logic signed [WIDTH:0]     t_wrapped;

   lcs_divider #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .long_mode (div_long),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      m_in         = m_ff;
      b_in         = b_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      bq_in        = bq_ff;
      rem_nz_in    = rem_nz_ff;
      tr_in        = tr_ff;
      sol_in       = sol_ff;
      ostep_in     = ostep_ff;
      gcd_in       = gcd_ff;
      status_in    = status_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      div_start    = 1'b0;
      div_long     = 1'b0;
      div_dividend = (2*WIDTH)'(r0_ff);
      div_divisor  = r1_ff;
      t_wrapped    = t0_ff + $signed({1'b0, step_ff});

      if (load) begin
         m_in  = modulus;
         b_in  = rhs_b;
         r0_in = modulus;
         r1_in = coef_a;
         t0_in = '0;
         t1_in = (WIDTH+1)'(1);
      end

      case (op)
         lcs_pkg::OP_NOP: begin
         end
         lcs_pkg::OP_DIV_EUCLID: begin
            div_start = 1'b1;
         end
         lcs_pkg::OP_MUL_QT: begin
            prod_in = (2*WIDTH+1)'($signed({1'b0, div_quot[WIDTH-1:0]}) * t1_ff);
         end
         lcs_pkg::OP_UPDATE: begin
            r0_in = r1_ff;
            r1_in = div_rem;
            t0_in = t1_ff;
            t1_in = t0_ff - $signed(prod_ff[WIDTH:0]);
         end
         lcs_pkg::OP_DIV_STEP: begin
            div_start    = 1'b1;
            div_dividend = (2*WIDTH)'(m_ff);
            div_divisor  = r0_ff;
         end
         lcs_pkg::OP_SAVE_STEP: begin
            step_in      = div_quot[WIDTH-1:0];
            div_start    = 1'b1;
            div_dividend = (2*WIDTH)'(b_ff);
            div_divisor  = r0_ff;
         end
         lcs_pkg::OP_SAVE_BQ: begin
            bq_in     = div_quot[WIDTH-1:0];
            rem_nz_in = div_rem != '0;
         end
         lcs_pkg::OP_FIX_T: begin
            tr_in = t0_ff[WIDTH] ? t_wrapped[WIDTH-1:0] : t0_ff[WIDTH-1:0];
         end
         lcs_pkg::OP_WRAP_T: begin
            if (tr_ff >= step_ff) begin
               tr_in = tr_ff - step_ff;
            end
         end
         lcs_pkg::OP_MUL_TB: begin
            prod_in = $signed({1'b0, (2*WIDTH)'(tr_ff) * (2*WIDTH)'(bq_ff)});
         end
         lcs_pkg::OP_DIV_SOL: begin
            div_start    = 1'b1;
            div_long     = 1'b1;
            div_dividend = prod_ff[2*WIDTH-1:0];
            div_divisor  = step_ff;
         end
         lcs_pkg::OP_FIN_OK: begin
            out_valid_in = 1'b1;
            sol_in       = div_rem;
            ostep_in     = step_ff;
            gcd_in       = r0_ff;
            status_in    = (r0_ff == WIDTH'(1)) ? lcs_pkg::STATUS_UNIQUE
                                                : lcs_pkg::STATUS_MULTI;
         end
         lcs_pkg::OP_FIN_NOSOL: begin
            out_valid_in = 1'b1;
            sol_in       = '0;
            ostep_in     = step_ff;
            gcd_in       = r0_ff;
            status_in    = lcs_pkg::STATUS_NONE;
         end
         lcs_pkg::OP_FIN_ERR: begin
            out_valid_in = 1'b1;
            sol_in       = '0;
            ostep_in     = '0;
            gcd_in       = '0;
            status_in    = lcs_pkg::STATUS_RANGE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      b_ff      <= b_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      prod_ff   <= prod_in;
      step_ff   <= step_in;
      bq_ff     <= bq_in;
      rem_nz_ff <= rem_nz_in;
      tr_ff     <= tr_in;
      sol_ff    <= sol_in;
      ostep_ff  <= ostep_in;
      gcd_ff    <= gcd_in;
      status_ff <= status_in;
   end

   always_comb begin
      flags.range_err   = (m_ff < WIDTH'(2)) || (r1_ff >= m_ff) || (b_ff >= m_ff);
      flags.r1_zero     = r1_ff == '0;
      flags.div_busy    = div_busy;
      flags.rem_nz      = rem_nz_ff;
      flags.out_blocked = out_valid_ff && !rsp_tready;
   end

   assign rsp_valid     = out_valid_ff;
   assign solution      = sol_ff;
   assign solution_step = ostep_ff;
   assign gcd_value     = gcd_ff;
   assign status        = status_ff;

   a_no_div_restart: assert property (@(posedge clock) disable iff (reset)
      (op == lcs_pkg::OP_DIV_EUCLID || op == lcs_pkg::OP_DIV_STEP ||
       op == lcs_pkg::OP_SAVE_STEP || op == lcs_pkg::OP_DIV_SOL) |-> !div_busy)
      else $error("divider started while busy");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (op == lcs_pkg::OP_FIN_OK || op == lcs_pkg::OP_FIN_NOSOL ||
       op == lcs_pkg::OP_FIN_ERR) |-> !(out_valid_ff && !rsp_tready))
      else $error("result written over a pending transfer");

endmodule

// File: rtl/lcs_sequencer.sv
// ----------------------------------------------------------------------------
// lcs_sequencer
// Step counter over the microcode table with conditional jumps. Holds on a
// finishing step while the result register is still occupied.
// ----------------------------------------------------------------------------
module lcs_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lcs_pkg::flags_type  flags,
   output logic                busy,
   output lcs_pkg::op_type     op
);

   logic [lcs_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic                       busy_ff, busy_in;
   lcs_pkg::ctrl_word_type     cw;
   logic                       take;
   logic                       stall;

   always_comb begin
      cw = lcs_pkg::ucode_rom(pc_ff);
      case (cw.cond)
         lcs_pkg::CND_NEVER:    take = 1'b0;
         lcs_pkg::CND_ALWAYS:   take = 1'b1;
         lcs_pkg::CND_RANGE:    take = flags.range_err;
         lcs_pkg::CND_R1_ZERO:  take = flags.r1_zero;
         lcs_pkg::CND_DIV_BUSY: take = flags.div_busy;
         lcs_pkg::CND_REM_NZ:   take = flags.rem_nz;
         default:               take = 1'b0;
      endcase
      stall   = busy_ff && cw.done && flags.out_blocked;
      busy_in = busy_ff;
      pc_in   = pc_ff;
      op      = lcs_pkg::OP_NOP;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = lcs_pkg::S_CHECK;
         end
      end else if (!stall) begin
         op = cw.op;
         if (cw.done) begin
            busy_in = 1'b0;
         end
         pc_in = take ? cw.target : pc_ff + lcs_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= lcs_pkg::S_CHECK;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> busy_ff && $stable(pc_ff))
      else $error("sequencer moved while result register full");

endmodule

// File: rtl/linear_congruence_solver_unit.sv
// ----------------------------------------------------------------------------
// linear_congruence_solver_unit
// Solves a*x = b (mod m) by the extended Euclidean algorithm, m from a
// configuration register.
// ----------------------------------------------------------------------------
// One item is worked at a time; req_tready is high while the sequencer is
// idle. Every Euclid round waits on the bit-serial divider, and there are
// up to about 23 rounds for 16-bit operands; an item without a solution
// ends sooner, and an operand out of range ends straight after the range
// check. The sequencer then goes idle, where the next transfer is taken.
// The result sits in an output register, so the next item is taken while
// it waits. Status: 0 unique, 1 no solution, 2 several solutions (first
// given), 3 operand out of range. The modulus resets to 961 and should
// only be written while no item is in flight.
module linear_congruence_solver_unit #(
   parameter int WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coef_a, rhs_b
   input  logic [((2*WIDTH + 7) / 8)*8-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // solution, solution_step, gcd_value
   output logic [((3*WIDTH + 7) / 8)*8-1:0]  rsp_tdata,
   // status
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [WIDTH-1:0]                  csr_data
);

   localparam int REQ_W = ((2*WIDTH + 7) / 8) * 8;
   localparam int RSP_W = ((3*WIDTH + 7) / 8) * 8;

   logic [WIDTH-1:0]     modulus_ff, modulus_in;
   logic                 req_xfer;
   logic                 seq_busy;
   lcs_pkg::op_type      op;
   lcs_pkg::flags_type   flags;
   logic [WIDTH-1:0]     solution;
   logic [WIDTH-1:0]     solution_step;
   logic [WIDTH-1:0]     gcd_value;
   lcs_pkg::status_type  status;

   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_data : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WIDTH'(lcs_pkg::MOD_RESET);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign req_tready = !seq_busy;
   assign req_xfer   = req_tvalid && req_tready;

   lcs_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_xfer),
      .flags (flags),
      .busy  (seq_busy),
      .op    (op)
   );

   lcs_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .load          (req_xfer),
      .coef_a        (req_tdata[WIDTH-1:0]),
      .rhs_b         (req_tdata[2*WIDTH-1:WIDTH]),
      .modulus       (modulus_ff),
      .op            (op),
      .rsp_tready    (rsp_tready),
      .flags         (flags),
      .rsp_valid     (rsp_tvalid),
      .solution      (solution),
      .solution_step (solution_step),
      .gcd_value     (gcd_value),
      .status        (status)
   );

   assign rsp_tdata = RSP_W'({gcd_value, solution_step, solution});
   assign rsp_tuser = status;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken while an item is in progress");

endmodule

// File: bench/linear_congruence_solver_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_congruence_solver_unit_test
// Self-checking bench for the linear congruence solver. Operand pairs are
// streamed in under several modulus settings, from degenerate ones (0, 1, 2)
// up to 65535, and every result is checked against a local extended Euclid
// model. Both stream sides idle at random, the result side also holds off
// for a long stretch once so that the unit stalls its input.
// ----------------------------------------------------------------------------
module linear_congruence_solver_unit_test;

   localparam int WIDTH       = 16;
   localparam int REQ_W       = 2 * WIDTH;
   localparam int RSP_W       = 3 * WIDTH;
   localparam int CLK_HALF    = 10;
   localparam int DRAIN_TICKS = 800;       // covers the worst item
   localparam int CYCLE_LIMIT = 5000000;
   localparam int HOLD_AT     = 150;       // results seen before the long hold-off
   localparam int HOLD_TICKS  = 3000;
   localparam int NUM_PHASES  = 15;

   typedef struct packed {
      logic [WIDTH-1:0] coef_a;
      logic [WIDTH-1:0] rhs_b;
   } operand_pair_type;

   typedef struct packed {
      logic [WIDTH-1:0]    solution;
      logic [WIDTH-1:0]    solution_step;
      logic [WIDTH-1:0]    gcd_value;
      lcs_pkg::status_type status;
   } congruence_result_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;  // coef_a, rhs_b
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // solution, solution_step, gcd_value
   logic [1:0]       rsp_tuser;         // status
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [WIDTH-1:0] csr_data    = '0;

   operand_pair_type      operand_queue[$];
   congruence_result_type solution_queue[$];
   logic [WIDTH-1:0]      modulus_model = WIDTH'(lcs_pkg::MOD_RESET);
   int                    mismatch_count = 0;
   int                    results_seen   = 0;
   int                    cycle_count    = 0;
   int                    req_gap        = 0;
   int                    rsp_gap        = 0;
   int                    hold_left      = 0;
   bit                    hold_done      = 1'b0;
   bit                    req_taken      = 1'b0;
   bit                    steady         = 1'b0;

   linear_congruence_solver_unit #(.WIDTH(WIDTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // gcd(a, m) and t with a * t = gcd (mod m), a below m
   function automatic logic [WIDTH-1:0] euclid_gcd(input logic [WIDTH-1:0] a,
                                                   input logic [WIDTH-1:0] m,
                                                   output longint coef);
      longint r0, r1, r2, t0, t1, t2, q;
      r0 = m;
      r1 = a;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         r2 = r0 - q * r1;
         t2 = t0 - q * t1;
         r0 = r1;
         r1 = r2;
         t0 = t1;
         t1 = t2;
      end
      coef = t0;
      return WIDTH'(r0);
   endfunction

   function automatic congruence_result_type solve_congruence(input logic [WIDTH-1:0] m,
                                                              input logic [WIDTH-1:0] a,
                                                              input logic [WIDTH-1:0] b);
      congruence_result_type res;
      longint t, g, stp, tr;
      res = '{solution: '0, solution_step: '0, gcd_value: '0,
              status: lcs_pkg::STATUS_RANGE};
      if (m >= 2 && a < m && b < m) begin
         g   = euclid_gcd(a, m, t);
         stp = m / g;
         res.gcd_value     = WIDTH'(g);
         res.solution_step = WIDTH'(stp);
         if (b % g != 0) begin
            res.status = lcs_pkg::STATUS_NONE;
         end else begin
            tr = ((t % stp) + stp) % stp;
            res.solution = WIDTH'((tr * (b / g)) % stp);
            res.status   = (g == 1) ? lcs_pkg::STATUS_UNIQUE : lcs_pkg::STATUS_MULTI;
         end
      end
      return res;
   endfunction

   // mostly no idling, a few short gaps, rarely a long one
   function automatic int pick_gap(input bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 60);
   endfunction

   task automatic add_random_pair(input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] a, b, g;
      longint t;
      int r;
      r = $urandom_range(0, 99);
      if (m < 2) begin
         a = WIDTH'($urandom);
         b = WIDTH'($urandom);
      end else if (r < 4) begin
         a = WIDTH'($urandom_range(m, 2**WIDTH - 1));
         b = WIDTH'($urandom);
      end else if (r < 8) begin
         a = WIDTH'($urandom_range(0, m - 1));
         b = WIDTH'($urandom_range(m, 2**WIDTH - 1));
      end else begin
         a = (r < 11) ? '0 : WIDTH'($urandom_range(0, m - 1));
         g = euclid_gcd(a, m, t);
         // push toward solvable cases when the gcd is above one
         if (r < 55)
            b = WIDTH'(g * $urandom_range(0, (m - 1) / g));
         else
            b = WIDTH'($urandom_range(0, m - 1));
      end
      operand_queue.push_back(operand_pair_type'{a, b});
   endtask

   task automatic write_modulus(input logic [WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      modulus_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_all_done();
      do @(posedge clock);
      while (operand_queue.size() != 0 || req_tvalid || solution_queue.size() != 0);
   endtask

   // request side: sample the transfer, then drive the next item
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         solution_queue.push_back(solve_congruence(modulus_model, req_tdata[WIDTH-1:0],
                                                   req_tdata[REQ_W-1:WIDTH]));
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   always @(negedge clock) begin
      operand_pair_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_gap    <= req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (operand_queue.size() > 0) begin
         item = operand_queue.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {item.rhs_b, item.coef_a};
         req_gap    <= pick_gap(steady);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_TICKS;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap    <= pick_gap(steady);
      end
   end

   always @(posedge clock) begin
      congruence_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (solution_queue.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h tuser %0d",
                   rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = solution_queue.pop_front();
            if (rsp_tdata[WIDTH-1:0] !== want.solution) begin
               $error("solution: expected %0d, got %0d", want.solution,
                      rsp_tdata[WIDTH-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[2*WIDTH-1:WIDTH] !== want.solution_step) begin
               $error("solution_step: expected %0d, got %0d", want.solution_step,
                      rsp_tdata[2*WIDTH-1:WIDTH]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_W-1:2*WIDTH] !== want.gcd_value) begin
               $error("gcd_value: expected %0d, got %0d", want.gcd_value,
                      rsp_tdata[RSP_W-1:2*WIDTH]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linear_congruence_solver_unit_test NOT OK");
         $finish;
      end
   end

   initial begin
      logic [WIDTH-1:0] mod_list[NUM_PHASES];
      int               item_count[NUM_PHASES];
      mod_list   = '{16'd961, 16'd65535, 16'd2, 16'd3, 16'd7, 16'd65520, 16'd1, 16'd0,
                     16'd4096, 16'd1023, 16'd65521, 16'd0, 16'd0, 16'd0, 16'd30030};
      item_count = '{150, 150, 40, 40, 60, 200, 20, 20, 150, 120, 120, 150, 150, 150, 100};
      for (int i = 11; i < 14; i++)
         mod_list[i] = WIDTH'($urandom_range(2, 2**WIDTH - 1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0)
            write_modulus(mod_list[p]);
         steady = (p % 4 == 2);
         if (p == 0) begin
            // modulus 961 = 31 * 31
            operand_queue.push_back(operand_pair_type'{16'd0,     16'd0});
            operand_queue.push_back(operand_pair_type'{16'd0,     16'd5});
            operand_queue.push_back(operand_pair_type'{16'd1,     16'd960});
            operand_queue.push_back(operand_pair_type'{16'd960,   16'd960});
            operand_queue.push_back(operand_pair_type'{16'd2,     16'd1});
            operand_queue.push_back(operand_pair_type'{16'd31,    16'd62});
            operand_queue.push_back(operand_pair_type'{16'd930,   16'd930});
            operand_queue.push_back(operand_pair_type'{16'd31,    16'd5});
            operand_queue.push_back(operand_pair_type'{16'd961,   16'd0});
            operand_queue.push_back(operand_pair_type'{16'd0,     16'd961});
            operand_queue.push_back(operand_pair_type'{16'd65535, 16'd65535});
         end else if (p == 1) begin
            operand_queue.push_back(operand_pair_type'{16'd65534, 16'd65534});
            operand_queue.push_back(operand_pair_type'{16'd65534, 16'd1});
            operand_queue.push_back(operand_pair_type'{16'd0,     16'd65534});
            operand_queue.push_back(operand_pair_type'{16'd21845, 16'd3});
            operand_queue.push_back(operand_pair_type'{16'd21845, 16'd4});
            operand_queue.push_back(operand_pair_type'{16'd65535, 16'd0});
            operand_queue.push_back(operand_pair_type'{16'd1,     16'd65535});
         end
         for (int n = 0; n < item_count[p]; n++) begin
            add_random_pair(mod_list[p]);
            // sender pause mid-phase until everything has drained
            if (p == 5 && n == 100)
               wait_all_done();
         end
         wait_all_done();
      end

      repeat (DRAIN_TICKS) @(posedge clock);
      if (mismatch_count == 0 && solution_queue.size() == 0)
         $display("linear_congruence_solver_unit_test OK");
      else
         $display("linear_congruence_solver_unit_test NOT OK");
      $finish;
   end

endmodule

// File: sim.f
rtl/lcs_pkg.sv
rtl/lcs_divider.sv
rtl/lcs_datapath.sv
rtl/lcs_sequencer.sv
rtl/linear_congruence_solver_unit.sv
bench/linear_congruence_solver_unit_test.sv
